>>> rtl/gwwb_pkg.sv
package gwwb_pkg;

  localparam int ADDR_BITS = 3;
  localparam int MAX_LINES = 3;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic REG_LINE_WIDTH  = 1'b0;
  localparam logic REG_SPACE_WIDTH = 1'b1;

  localparam logic [9:0] LINE_WIDTH_RST  = 10'd320;
  localparam logic [5:0] SPACE_WIDTH_RST = 6'd6;

  typedef struct packed {
    logic [15:0] start_index;
    logic [15:0] char_count;
    logic [9:0]  pixel_width;
    logic        hard_break;
  } line_t;

endpackage

>>> rtl/greedy_word_wrap_breaker.sv
// Greedy word-wrap line breaker. Takes one character per cycle with its glyph
// width and returns one transaction per finished line (start index, character
// count, pixel width, hard-break flag). All line-breaking decisions for a
// character are made in the cycle it is accepted, so a character can enter on
// every clock. One character yields zero to three lines, which leave one per
// cycle unless out_stall is set from a two-entry result queue, so input stalls
// only while the queue is full, when lines leave slower than characters enter.
// line_width sits at address 0 and space_width at address 4; write them only
// while no lines are pending.
module greedy_word_wrap_breaker #(
  parameter int INDEX_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gwwb_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_char_code,
  input  logic [5:0]                     in_glyph_width,
  input  logic                           in_end_of_text,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_start_index,
  output logic [15:0]                    out_char_count,
  output logic [9:0]                     out_pixel_width,
  output logic                           out_hard_break,
  output logic                           out_last_of_run
);
  import gwwb_pkg::*;

  localparam logic [INDEX_BITS-1:0] IDX_ONE = INDEX_BITS'(1);

  logic [9:0] line_width_r;
  logic [5:0] space_width_r;

  logic [INDEX_BITS-1:0] char_index_r, char_index_nxt;
  logic [INDEX_BITS-1:0] line_begin_r, line_begin_nxt;
  logic [INDEX_BITS-1:0] seg_begin_r, seg_begin_nxt;
  logic [9:0]            line_pixels_r, line_pixels_nxt;
  logic [9:0]            seg_pixels_r, seg_pixels_nxt;
  logic                  blank_run_r, blank_run_nxt;
  logic                  seg_open_r, seg_open_nxt;

  line_t       res_lines[MAX_LINES];
  logic [1:0]  res_cnt;

  line_t       bun_line_r[2][MAX_LINES];
  logic [1:0]  bun_cnt_r[2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  fill_r;
  logic [1:0]  sub_r;

  logic        cfg_wr;
  logic        in_acc;
  logic        push;
  logic        pop_line;
  logic        last_line;
  logic        pop_bundle;
  line_t       cur_line;

  function automatic line_t mk_line(input logic [INDEX_BITS-1:0] start,
                                    input logic [INDEX_BITS-1:0] count,
                                    input logic [11:0] pix,
                                    input logic hard);
    line_t l;
    l.start_index = 16'(start);
    l.char_count  = 16'(count);
    l.pixel_width = pix[9:0];
    l.hard_break  = hard;
    return l;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_SPACE_WIDTH) ? {26'd0, space_width_r}
                                                : {22'd0, line_width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= LINE_WIDTH_RST;
      space_width_r <= SPACE_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LINE_WIDTH:  line_width_r  <= pwdata[9:0];
        REG_SPACE_WIDTH: space_width_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // line-breaking step for one character
  always_comb begin : step_p
    logic [INDEX_BITS-1:0] i, lb, sb, cnt;
    logic [11:0] lp, sp, lw, sw, unit, t1, t2, t3, t4;
    logic        so, br, is_brk, is_tab, blank, alone, whole;
    logic [1:0]  n;

    i      = char_index_r;
    lb     = line_begin_r;
    sb     = seg_begin_r;
    lp     = 12'(line_pixels_r);
    sp     = 12'(seg_pixels_r);
    so     = seg_open_r;
    br     = blank_run_r;
    lw     = 12'(line_width_r);
    sw     = 12'(space_width_r);
    n      = 2'd0;
    alone  = 1'b0;
    whole  = 1'b1;
    is_brk = (in_char_code == CH_LF) || (in_char_code == CH_CR);
    is_tab = (in_char_code == CH_TAB);
    blank  = is_tab || (in_char_code == CH_SPACE);
    unit   = blank ? sw : 12'(in_glyph_width);
    t1     = sp + sw;
    t2     = sp + (sw << 1);
    t3     = t2 + sw;
    t4     = sp + (sw << 2);
    cnt    = '0;
    for (int k = 0; k < MAX_LINES; k++) res_lines[k] = '0;

    if (is_brk) begin
      if (so) begin
        lp = lp + sp;
        sp = '0;
        so = 1'b0;
        br = 1'b0;
      end
      res_lines[n] = mk_line(lb, i - lb, lp, 1'b1);
      n  = n + 2'd1;
      lb = i + IDX_ONE;
      lp = '0;
    end else begin
      if (!blank && so && br) begin
        lp = lp + sp;
        sp = '0;
        so = 1'b0;
        br = 1'b0;
      end
      if (!is_tab && so && (sp + unit > lw)) begin
        lp = lp + sp;
        sp = '0;
        so = 1'b0;
        br = 1'b0;
      end
      if (!so) begin
        if (!is_tab && (unit > lw)) begin
          if (i != lb) begin
            res_lines[n] = mk_line(lb, i - lb, lp, 1'b0);
            n = n + 2'd1;
          end
          res_lines[n] = mk_line(i, IDX_ONE, unit, 1'b0);
          n     = n + 2'd1;
          lb    = i + IDX_ONE;
          lp    = '0;
          alone = 1'b1;
        end else begin
          sb = i;
          sp = '0;
          so = 1'b1;
          br = blank;
          t1 = sw;
          t2 = sw << 1;
          t3 = t2 + sw;
          t4 = sw << 2;
        end
      end
      if (!alone) begin
        if (blank) br = 1'b1;
        if (is_tab) begin
          whole = (t4 <= lw);
          if (t4 <= lw)      sp = t4;
          else if (t3 <= lw) sp = t3;
          else if (t2 <= lw) sp = t2;
          else if (t1 <= lw) sp = t1;
        end else begin
          sp = sp + unit;
        end
        if (lp + sp > lw) begin
          res_lines[n] = mk_line(lb, sb - lb, lp, 1'b0);
          n  = n + 2'd1;
          lb = sb;
          lp = '0;
        end
        if (is_tab && !whole) begin
          lp = lp + sp;
          sp = '0;
          so = 1'b0;
          br = 1'b0;
        end
      end
    end

    if (in_end_of_text) begin
      cnt = i + IDX_ONE - lb;
      if ((cnt != '0) || so) begin
        res_lines[n] = mk_line(lb, cnt, lp + (so ? sp : 12'd0), 1'b0);
        n = n + 2'd1;
      end
      char_index_nxt  = '0;
      line_begin_nxt  = '0;
      seg_begin_nxt   = '0;
      line_pixels_nxt = '0;
      seg_pixels_nxt  = '0;
      blank_run_nxt   = 1'b0;
      seg_open_nxt    = 1'b0;
    end else begin
      char_index_nxt  = i + IDX_ONE;
      line_begin_nxt  = lb;
      seg_begin_nxt   = sb;
      line_pixels_nxt = lp[9:0];
      seg_pixels_nxt  = sp[9:0];
      blank_run_nxt   = br;
      seg_open_nxt    = so;
    end
    res_cnt = n;
  end

  assign in_stall = (fill_r == 2'd2);
  assign in_acc   = in_valid & ~in_stall;
  assign push     = in_acc & (res_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_index_r  <= '0;
      line_begin_r  <= '0;
      seg_begin_r   <= '0;
      line_pixels_r <= '0;
      seg_pixels_r  <= '0;
      blank_run_r   <= 1'b0;
      seg_open_r    <= 1'b0;
    end else if (in_acc) begin
      char_index_r  <= char_index_nxt;
      line_begin_r  <= line_begin_nxt;
      seg_begin_r   <= seg_begin_nxt;
      line_pixels_r <= line_pixels_nxt;
      seg_pixels_r  <= seg_pixels_nxt;
      blank_run_r   <= blank_run_nxt;
      seg_open_r    <= seg_open_nxt;
    end
  end

  // result queue: one entry per line-yielding character, drained line by line
  assign out_valid  = (fill_r != 2'd0);
  assign pop_line   = out_valid & ~out_stall;
  assign last_line  = (sub_r == (bun_cnt_r[rd_ptr_r] - 2'd1));
  assign pop_bundle = pop_line & last_line;
  assign cur_line   = bun_line_r[rd_ptr_r][sub_r];

  assign out_start_index = cur_line.start_index;
  assign out_char_count  = cur_line.char_count;
  assign out_pixel_width = cur_line.pixel_width;
  assign out_hard_break  = cur_line.hard_break;
  assign out_last_of_run = last_line;

  always_ff @(posedge clk) begin
    if (push) begin
      bun_line_r[wr_ptr_r] <= res_lines;
      bun_cnt_r[wr_ptr_r]  <= res_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
      sub_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop_bundle) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop_bundle};
      if (pop_line) sub_r <= last_line ? 2'd0 : sub_r + 2'd1;
    end
  end

endmodule
